// File: hw/rtl/gkle_pkg.sv
// ----------------------------------------------------------------------------
// gkle_pkg: shared types and constants of the grid keyboard line editor
// Holds the grid layout, key codes, item and result types and the state
// record that the step logic and the top level exchange.
// ----------------------------------------------------------------------------
package gkle_pkg;

  localparam int TEXT_CAP = 64;

  localparam logic [3:0] GRID_COLS     = 4'd10;
  localparam logic [3:0] LAST_ROW_COLS = 4'd9;
  localparam logic [1:0] LAST_ROW      = 2'd3;

  localparam logic [5:0] SLOT_SPACE  = 6'd36;
  localparam logic [5:0] SLOT_DELETE = 6'd37;
  localparam logic [5:0] SLOT_OK     = 6'd38;

  localparam logic [7:0] EVENT_FIRE  = 8'h01;
  localparam logic [7:0] KEY_DELETE  = 8'h2A;
  localparam logic [7:0] KEY_ACCEPT  = 8'h23;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [5:0] LETTER_CNT  = 6'd26;

  localparam logic [6:0] MAX_LENGTH_RST   = 7'd16;
  localparam logic [7:0] FIRST_DELAY_RST  = 8'd18;
  localparam logic [7:0] NEXT_DELAY_RST   = 8'd5;

  typedef enum logic [1:0] {
    REG_MAX_LENGTH  = 2'd0,
    REG_FIRST_DELAY = 2'd1,
    REG_NEXT_DELAY  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_PRELOAD = 2'd1,
    ACT_BEGIN   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    OUT_NONE     = 3'd0,
    OUT_APPENDED = 3'd1,
    OUT_DELETED  = 3'd2,
    OUT_FULL     = 3'd3,
    OUT_EMPTY    = 3'd4,
    OUT_ACCEPTED = 3'd5
  } outcome_e;

  typedef struct packed {
    logic [6:0] max_length;
    logic [7:0] first_delay;
    logic [7:0] next_delay;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] direction;
    logic [7:0] keypad_code;
    logic       fire;
    logic [7:0] preload_char;
  } item_t;

  typedef struct packed {
    logic [3:0] cur_x;
    logic [1:0] cur_y;
    logic [3:0] prev_dir;
    logic [7:0] countdown;
    logic [7:0] prev_event;
    logic [6:0] length;
    logic       done;
  } state_t;

  typedef struct packed {
    logic [3:0] cursor_col;
    logic [1:0] cursor_row;
    logic       moved;
    outcome_e   outcome;
    logic [7:0] edit_char;
    logic [6:0] text_length;
    logic       finished;
  } result_t;

  function automatic logic [3:0] row_width(logic [1:0] row);
    row_width = (row == LAST_ROW) ? LAST_ROW_COLS : GRID_COLS;
  endfunction

  // Cells below the space cell: letters first, then the digits.
  function automatic logic [7:0] grid_char(logic [5:0] idx);
    logic [5:0] digit;
    digit = idx - LETTER_CNT;
    if (idx < LETTER_CNT) begin
      grid_char = CHAR_A + 8'(idx);
    end else begin
      grid_char = CHAR_ZERO + 8'(digit);
    end
  endfunction

endpackage

// File: hw/rtl/gkle_step.sv
// ----------------------------------------------------------------------------
// gkle_step: next-state logic of the line editor for one item
// Computes the cursor move, auto-repeat countdown, key event decode and the
// text length update for one beat, together with its result.
// ----------------------------------------------------------------------------
module gkle_step (
  input  gkle_pkg::state_t  st_i,
  input  gkle_pkg::cfg_t    cfg_i,
  input  gkle_pkg::item_t   item_i,
  output gkle_pkg::state_t  st_o,
  output gkle_pkg::result_t res_o
);
  import gkle_pkg::*;

  always_comb begin
    state_t     st;
    outcome_e   outcome;
    logic       moved;
    logic [7:0] edit_ch;
    logic [3:0] move;
    logic [7:0] evt;
    logic [7:0] cd_dec;
    logic [3:0] width;
    logic [3:0] width_new;
    logic [5:0] idx;
    logic       want_app;
    logic [7:0] app_ch;
    logic       do_delete;
    logic       do_ok;

    st        = st_i;
    outcome   = OUT_NONE;
    moved     = 1'b0;
    edit_ch   = 8'd0;
    move      = 4'd0;
    evt       = 8'd0;
    cd_dec    = st_i.countdown - 8'd1;
    width     = row_width(st_i.cur_y);
    width_new = width;
    idx       = 6'd0;
    want_app  = 1'b0;
    app_ch    = 8'd0;
    do_delete = 1'b0;
    do_ok     = 1'b0;

    case (action_e'(item_i.action))
      ACT_TICK: begin
        if (!st_i.done) begin
          if (item_i.keypad_code != 8'd0) begin
            evt = item_i.keypad_code;
          end else if (item_i.fire) begin
            evt = EVENT_FIRE;
          end

          if (item_i.direction != st_i.prev_dir) begin
            st.prev_dir  = item_i.direction;
            st.countdown = cfg_i.first_delay;
            move         = item_i.direction;
          end else if (item_i.direction != 4'd0) begin
            if (cd_dec == 8'd0) begin
              st.countdown = cfg_i.next_delay;
              move         = item_i.direction;
            end else begin
              st.countdown = cd_dec;
            end
          end

          // Left, right, up, down in that order; a blocked one falls through.
          if (move != 4'd0) begin
            if (move[2] && st_i.cur_x != 4'd0) begin
              st.cur_x = st_i.cur_x - 4'd1;
            end else if (move[3] && st_i.cur_x < width - 4'd1) begin
              st.cur_x = st_i.cur_x + 4'd1;
            end else if (move[0] && st_i.cur_y != 2'd0) begin
              st.cur_y = st_i.cur_y - 2'd1;
            end else if (move[1] && st_i.cur_y != LAST_ROW) begin
              st.cur_y = st_i.cur_y + 2'd1;
            end
            width_new = row_width(st.cur_y);
            if (st.cur_x >= width_new) begin
              st.cur_x = width_new - 4'd1;
            end
            moved = 1'b1;
          end

          idx = 6'({st.cur_y, 3'b000}) + 6'({st.cur_y, 1'b0}) + 6'(st.cur_x);

          if (evt != st_i.prev_event) begin
            st.prev_event = evt;
            if (evt inside {[CHAR_ZERO:CHAR_NINE]}) begin
              want_app = 1'b1;
              app_ch   = evt;
            end else if (evt == KEY_DELETE) begin
              do_delete = 1'b1;
            end else if (evt == KEY_ACCEPT) begin
              do_ok = 1'b1;
            end else if (evt == EVENT_FIRE) begin
              if (idx == SLOT_OK) begin
                do_ok = 1'b1;
              end else if (idx == SLOT_DELETE) begin
                do_delete = 1'b1;
              end else if (idx == SLOT_SPACE) begin
                want_app = 1'b1;
                app_ch   = CHAR_SPACE;
              end else if (idx < SLOT_SPACE) begin
                want_app = 1'b1;
                app_ch   = grid_char(idx);
              end
            end
          end
        end
      end
      ACT_PRELOAD: begin
        want_app = 1'b1;
        app_ch   = item_i.preload_char;
      end
      ACT_BEGIN: begin
        st = '0;
      end
      default: begin
      end
    endcase

    if (want_app) begin
      if ({1'b0, st_i.length} >= {1'b0, cfg_i.max_length} ||
          {1'b0, st_i.length} >= 8'(TEXT_CAP)) begin
        outcome = OUT_FULL;
      end else begin
        st.length = st_i.length + 7'd1;
        edit_ch   = app_ch;
        outcome   = OUT_APPENDED;
      end
    end else if (do_delete) begin
      if (st_i.length == 7'd0) begin
        outcome = OUT_EMPTY;
      end else begin
        st.length = st_i.length - 7'd1;
        outcome   = OUT_DELETED;
      end
    end else if (do_ok) begin
      if (st_i.length == 7'd0) begin
        outcome = OUT_EMPTY;
      end else begin
        st.done = 1'b1;
        outcome = OUT_ACCEPTED;
      end
    end

    st_o              = st;
    res_o.cursor_col  = st.cur_x;
    res_o.cursor_row  = st.cur_y;
    res_o.moved       = moved;
    res_o.outcome     = outcome;
    res_o.edit_char   = edit_ch;
    res_o.text_length = st.length;
    res_o.finished    = st.done;
  end

endmodule

// File: hw/rtl/grid_keyboard_line_editor_unit.sv
// ----------------------------------------------------------------------------
// grid_keyboard_line_editor_unit: on-screen keyboard line editor
// Moves a cursor over a character grid from stick input, with auto-repeat,
// and edits one line of text from keypad and fire events.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                              Payload
//  s_axis    in         tvalid tready tdata[23:0] tuser[1:0] one input item
//  m_axis    out        tvalid tready tdata[31:0]            one result
//  cfg       in         cfg_we_i cfg_idx_i cfg_data_i        register write
//
//  A beat is registered on entry, processed by the step logic and held
//  in the result register, from which its result is offered on m_axis.
//  Sustains one beat per cycle while m_axis is ready; editor state is the loop.
//  Reset restores the register defaults and clears the editor state at once.
//  A stalled result holds the pipe; input is taken while the step is free.
// ----------------------------------------------------------------------------
module grid_keyboard_line_editor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // direction[3:0], keypad_code[11:4], fire[12], preload_char[20:13], zero
  input  logic [23:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cursor_col[3:0], cursor_row[5:4], moved[6], outcome[9:7],
  // edit_char[17:10], text_length[24:18], finished[25], zero
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import gkle_pkg::*;

  cfg_t    cfg_q;
  state_t  st_q;
  state_t  st_d;
  item_t   in_q;
  logic    in_vld_q;
  result_t out_q;
  result_t res_d;
  logic    out_vld_q;
  logic    advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_q.finished, out_q.text_length, out_q.edit_char,
                          out_q.outcome, out_q.moved, out_q.cursor_row, out_q.cursor_col};

  gkle_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .item_i (in_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_length  <= MAX_LENGTH_RST;
      cfg_q.first_delay <= FIRST_DELAY_RST;
      cfg_q.next_delay  <= NEXT_DELAY_RST;
      st_q              <= '0;
      in_vld_q          <= 1'b0;
      out_vld_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_MAX_LENGTH:  cfg_q.max_length  <= cfg_data_i[6:0];
          REG_FIRST_DELAY: cfg_q.first_delay <= cfg_data_i;
          REG_NEXT_DELAY:  cfg_q.next_delay  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        st_q      <= st_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.action       <= s_axis_tuser;
      in_q.direction    <= s_axis_tdata[3:0];
      in_q.keypad_code  <= s_axis_tdata[11:4];
      in_q.fire         <= s_axis_tdata[12];
      in_q.preload_char <= s_axis_tdata[20:13];
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, st_q.length} <= 8'(TEXT_CAP))
    else $error("text length beyond capacity");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.cur_x < row_width(st_q.cur_y))
    else $error("cursor outside its row");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(st_q))
    else $error("editor state changed without a beat");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled with room in the pipe");

  a_result_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("processed beat produced no result");
`endif

endmodule

// File: test/grid_keyboard_line_editor_unit_tb.sv
// ----------------------------------------------------------------------------
// grid_keyboard_line_editor_unit_tb: self-checking bench for the line editor
// Sends frame ticks, preloads and begin actions on the input stream. A
// behavioral copy of the editor predicts every result beat, and a monitor
// compares each beat field by field. Both sides idle at random, and the
// register settings change between phases.
// ----------------------------------------------------------------------------
module grid_keyboard_line_editor_unit_tb;
  import gkle_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  localparam logic [3:0] DIR_NONE  = 4'b0000;
  localparam logic [3:0] DIR_UP    = 4'b0001;
  localparam logic [3:0] DIR_DOWN  = 4'b0010;
  localparam logic [3:0] DIR_LEFT  = 4'b0100;
  localparam logic [3:0] DIR_RIGHT = 4'b1000;
  localparam logic [3:0] DIR_ALL   = 4'b1111;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [7:0]  cfg_data_i    = '0;

  grid_keyboard_line_editor_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Register copies and editor state of the behavioral model.
  logic [6:0] lim_len   = MAX_LENGTH_RST;
  logic [7:0] first_dly = FIRST_DELAY_RST;
  logic [7:0] next_dly  = NEXT_DELAY_RST;
  logic [3:0] ed_col    = '0;
  logic [1:0] ed_row    = '0;
  logic [3:0] ed_dir    = '0;
  logic [7:0] ed_count  = '0;
  logic [7:0] ed_event  = '0;
  logic [6:0] ed_len    = '0;
  logic       ed_done   = 1'b0;

  result_t    editor_view_q[$];
  logic [7:0] key_last   = '0;
  bit         tx_steady  = 1'b0;
  bit         rx_steady  = 1'b0;
  int         rx_hold    = 0;
  int         err_cnt    = 0;
  int         beat_cnt   = 0;
  int         cycle_cnt  = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [3:0] cols_in_row(logic [1:0] row);
    return (row == LAST_ROW) ? LAST_ROW_COLS : GRID_COLS;
  endfunction

  function automatic outcome_e text_append(logic [7:0] ch, output logic [7:0] typed);
    int cap;
    cap = (lim_len < TEXT_CAP) ? int'(lim_len) : TEXT_CAP;
    typed = 8'h00;
    if (int'(ed_len) >= cap) return OUT_FULL;
    ed_len++;
    typed = ch;
    return OUT_APPENDED;
  endfunction

  function automatic void wipe_entry();
    ed_col   = '0;
    ed_row   = '0;
    ed_dir   = '0;
    ed_count = '0;
    ed_event = '0;
    ed_len   = '0;
    ed_done  = 1'b0;
  endfunction

  function automatic result_t editor_step(item_t it);
    result_t    r;
    logic [7:0] ev;
    logic [3:0] mv;
    logic [7:0] ch;
    int         slot;
    r  = '0;
    mv = '0;
    case (it.action)
      ACT_TICK: begin
        if (!ed_done) begin
          ev = (it.keypad_code != 8'h00) ? it.keypad_code : (it.fire ? EVENT_FIRE : 8'h00);
          if (it.direction != ed_dir) begin
            ed_dir   = it.direction;
            ed_count = first_dly;
            mv       = it.direction;
          end else if (it.direction != DIR_NONE) begin
            ed_count = ed_count - 8'd1;
            if (ed_count == 8'd0) begin
              ed_count = next_dly;
              mv       = it.direction;
            end
          end
          if (mv != DIR_NONE) begin
            if (mv[2] && ed_col > 0) begin
              ed_col--;
            end else if (mv[3] && ed_col + 1 < cols_in_row(ed_row)) begin
              ed_col++;
            end else if (mv[0] && ed_row > 0) begin
              ed_row--;
            end else if (mv[1] && ed_row < LAST_ROW) begin
              ed_row++;
            end
            if (ed_col >= cols_in_row(ed_row)) ed_col = cols_in_row(ed_row) - 4'd1;
            r.moved = 1'b1;
          end
          if (ev != ed_event) begin
            ed_event = ev;
            if (ev >= CHAR_ZERO && ev <= CHAR_NINE) begin
              r.outcome = text_append(ev, r.edit_char);
            end else if (ev == KEY_DELETE || ev == KEY_ACCEPT || ev == EVENT_FIRE) begin
              slot = int'(ed_row) * int'(GRID_COLS) + int'(ed_col);
              if (ev == KEY_DELETE) slot = SLOT_DELETE;
              if (ev == KEY_ACCEPT) slot = SLOT_OK;
              if (slot == SLOT_OK || slot == SLOT_DELETE) begin
                if (ed_len == 0) begin
                  r.outcome = OUT_EMPTY;
                end else if (slot == SLOT_OK) begin
                  ed_done   = 1'b1;
                  r.outcome = OUT_ACCEPTED;
                end else begin
                  ed_len--;
                  r.outcome = OUT_DELETED;
                end
              end else if (slot == SLOT_SPACE) begin
                r.outcome = text_append(CHAR_SPACE, r.edit_char);
              end else if (slot < SLOT_SPACE) begin
                ch = (slot < LETTER_CNT) ? CHAR_A + 8'(slot) : CHAR_ZERO + 8'(slot - LETTER_CNT);
                r.outcome = text_append(ch, r.edit_char);
              end
            end
          end
        end
      end
      ACT_PRELOAD: begin
        r.outcome = text_append(it.preload_char, r.edit_char);
      end
      ACT_BEGIN: begin
        wipe_entry();
      end
      default: begin
      end
    endcase
    r.cursor_col  = ed_col;
    r.cursor_row  = ed_row;
    r.text_length = ed_len;
    r.finished    = ed_done;
    return r;
  endfunction

  function automatic item_t frame_item(logic [1:0] act, logic [3:0] dir, logic [7:0] key,
                                       logic fire, logic [7:0] ch);
    item_t it;
    it.action       = act;
    it.direction    = dir;
    it.keypad_code  = key;
    it.fire         = fire;
    it.preload_char = ch;
    return it;
  endfunction

  function automatic item_t random_item();
    return frame_item(2'($urandom_range(0, 2)), 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
  endfunction

  // Keys are often held for several frames, so the last one is kept.
  function automatic logic [7:0] pick_key(bit allow_accept);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      key_last = 8'h00;
    end else if (r < 55) begin
      key_last = CHAR_ZERO + 8'($urandom_range(0, 9));
    end else if (r < 63) begin
      key_last = KEY_DELETE;
    end else if (r < 66 && allow_accept) begin
      key_last = KEY_ACCEPT;
    end else if (r < 75) begin
      key_last = EVENT_FIRE;
    end else if (r < 85) begin
      key_last = 8'($urandom_range(0, 255));
      if (!allow_accept && key_last == KEY_ACCEPT) key_last = 8'h00;
    end
    return key_last;
  endfunction

  task automatic flag_mismatch(input string what, input int got_v, input int want_v);
    err_cnt++;
    if (err_cnt <= 50) begin
      $display("beat %0d: %s is %0d, expected %0d", beat_cnt, what, got_v, want_v);
    end
  endtask

  task automatic send_item(input item_t it);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.action;
    s_axis_tdata  <= {3'b000, it.preload_char, it.fire, it.keypad_code, it.direction};
    do @(posedge clk_i); while (!s_axis_tready);
    editor_view_q.push_back(editor_step(it));
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (editor_view_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] max_len, input logic [7:0] dly_a,
                              input logic [7:0] dly_b);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MAX_LENGTH;
    cfg_data_i <= max_len;
    @(posedge clk_i);
    cfg_idx_i  <= REG_FIRST_DELAY;
    cfg_data_i <= dly_a;
    @(posedge clk_i);
    cfg_idx_i  <= REG_NEXT_DELAY;
    cfg_data_i <= dly_b;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    lim_len   = max_len[6:0];
    first_dly = dly_a;
    next_dly  = dly_b;
  endtask

  // Held stick directions with keypad traffic, plus preloads, begins and noise.
  task automatic run_session(input int count, input int preload_pct, input int begin_pct,
                             input bit allow_accept);
    item_t      it;
    logic [3:0] dir;
    int         hold_left;
    int         r;
    hold_left = 0;
    dir       = DIR_NONE;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      if (hold_left == 0) begin
        case ($urandom_range(0, 5))
          0:       dir = DIR_NONE;
          1, 2, 3: dir = DIR_UP << $urandom_range(0, 3);
          4:       dir = (DIR_UP << $urandom_range(0, 3)) | (DIR_UP << $urandom_range(0, 3));
          default: dir = 4'($urandom_range(0, 15));
        endcase
        hold_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      end
      hold_left--;
      it = random_item();
      r  = $urandom_range(0, 99);
      if (ed_done && r < 40) begin
        it.action = ACT_BEGIN;
      end else if (r < begin_pct) begin
        it.action = ACT_BEGIN;
      end else if (r < begin_pct + preload_pct) begin
        it.action = ACT_PRELOAD;
      end else if (r == 99) begin
        it.action = ACT_UNKNOWN;
      end else begin
        it.action      = ACT_TICK;
        it.direction   = dir;
        it.keypad_code = pick_key(allow_accept);
        it.fire        = ($urandom_range(0, 2) == 0);
      end
      send_item(it);
    end
  endtask

  task automatic test_reset_defaults();
    run_session(60, 5, 1, 1'b1);
  endtask

  task automatic test_directed_edits();
    settle();
    program_regs(8'd2, 8'd1, 8'd1);
    send_item(frame_item(ACT_TICK, DIR_NONE, 8'h00, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_RIGHT, CHAR_ZERO + 8'd7, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_RIGHT, CHAR_ZERO + 8'd7, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_RIGHT, 8'h00, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_RIGHT, 8'h00, 1'b1, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_RIGHT, 8'hFF, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_RIGHT, CHAR_ZERO + 8'd5, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_RIGHT, 8'h00, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_RIGHT, 8'h00, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_RIGHT, 8'h00, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_ALL, 8'h00, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_RIGHT, 8'h00, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_DOWN, 8'h00, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_DOWN, 8'h00, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_DOWN, KEY_DELETE, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_LEFT, 8'h00, 1'b1, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_LEFT, 8'h00, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_NONE, 8'h00, 1'b1, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_NONE, KEY_ACCEPT, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_RIGHT, CHAR_ZERO + 8'd1, 1'b0, 8'h00));
    send_item(frame_item(ACT_PRELOAD, DIR_NONE, 8'h00, 1'b0, 8'h5A));
    send_item(frame_item(ACT_PRELOAD, DIR_NONE, 8'h00, 1'b0, 8'h00));
    send_item(frame_item(ACT_UNKNOWN, DIR_ALL, 8'hFF, 1'b1, 8'hFF));
    send_item(frame_item(ACT_BEGIN, DIR_NONE, 8'h00, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_NONE, KEY_ACCEPT, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_NONE, KEY_DELETE, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_UP, EVENT_FIRE, 1'b0, 8'h00));
    send_item(frame_item(ACT_TICK, DIR_UP, 8'h00, 1'b1, 8'h00));
  endtask

  task automatic test_random_settings();
    settle();
    program_regs(8'd0, 8'd1, 8'd1);
    run_session(40, 10, 2, 1'b1);
    settle();
    program_regs(8'd1, 8'd2, 8'd1);
    run_session(40, 10, 2, 1'b1);
    settle();
    program_regs(8'd3, 8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
    run_session(40, 10, 2, 1'b1);
    settle();
    program_regs(8'd127, 8'd3, 8'd2);
    run_session(50, 70, 0, 1'b0);
    settle();
    program_regs(8'd64, 8'd1, 8'd3);
    run_session(40, 50, 0, 1'b1);
    settle();
    program_regs(8'($urandom_range(1, 64)), 8'($urandom_range(1, 10)),
                 8'($urandom_range(1, 10)));
    run_session(40, 15, 2, 1'b1);
  endtask

  task automatic test_backpressure();
    settle();
    rx_steady = 1'b0;
    tx_steady = 1'b1;
    rx_hold   = 150;
    repeat (20) send_item(random_item());
    tx_steady = 1'b0;
  endtask

  // The shortest first delay, then a next delay of zero that wraps to 256 frames.
  task automatic test_repeat_extremes();
    item_t it;
    settle();
    program_regs(8'd64, 8'd1, 8'd0);
    send_item(frame_item(ACT_BEGIN, DIR_NONE, 8'h00, 1'b0, 8'h00));
    repeat (260) begin
      it             = random_item();
      it.action      = ACT_TICK;
      it.direction   = DIR_UP | DIR_LEFT;
      it.keypad_code = pick_key(1'b0);
      send_item(it);
    end
  endtask

  initial begin : result_monitor
    result_t     got;
    result_t     want;
    logic [31:0] d;
    int          stall;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall   = (rx_hold > 0) ? rx_hold : (rx_steady ? 0 : $urandom_range(0, 9));
      rx_hold = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      d = m_axis_tdata;
      beat_cnt++;
      if (editor_view_q.size() == 0) begin
        flag_mismatch("result beat with nothing pending", int'(d), 0);
      end else begin
        want            = editor_view_q.pop_front();
        got.cursor_col  = d[3:0];
        got.cursor_row  = d[5:4];
        got.moved       = d[6];
        got.outcome     = outcome_e'(d[9:7]);
        got.edit_char   = d[17:10];
        got.text_length = d[24:18];
        got.finished    = d[25];
        if (got.cursor_col !== want.cursor_col)
          flag_mismatch("cursor_col", got.cursor_col, want.cursor_col);
        if (got.cursor_row !== want.cursor_row)
          flag_mismatch("cursor_row", got.cursor_row, want.cursor_row);
        if (got.moved !== want.moved)
          flag_mismatch("moved", got.moved, want.moved);
        if (got.outcome !== want.outcome)
          flag_mismatch("outcome", got.outcome, want.outcome);
        if (got.edit_char !== want.edit_char)
          flag_mismatch("edit_char", got.edit_char, want.edit_char);
        if (got.text_length !== want.text_length)
          flag_mismatch("text_length", got.text_length, want.text_length);
        if (got.finished !== want.finished)
          flag_mismatch("finished", got.finished, want.finished);
      end
    end
  end

  initial begin
    do @(posedge clk_i); while (!rst_ni);
    test_reset_defaults();
    test_directed_edits();
    test_random_settings();
    test_backpressure();
    test_repeat_extremes();
    settle();
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0 && editor_view_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
